>>> rtl/rational_accumulator_defines.svh
// Assertion macros for the rational accumulator checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RATIONAL_ACCUMULATOR_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rational accumulator assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define RA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rational accumulator assertion failed");

`endif

>>> rtl/ra_pkg.sv
// Shared constants and word types of the rational accumulator.
// No dependencies.
`timescale 1ns / 1ps
package ra_pkg;
	localparam int VALUE_WIDTH = 32;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_ADD     = 2'd1;
	localparam logic [1:0] KIND_COMPARE = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] operand_num;
		logic signed [31:0] operand_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_num;
		logic [30:0]        result_den;
		logic               is_nonzero;
		logic               is_less;
		logic               is_equal;
		logic               overflow;
	} rsp_t;
endpackage

>>> rtl/rational_accumulator.sv
// Rational accumulator top level: sequencer, bit-serial multiplier, binary gcd, serial divider.
// Depends on ra_pkg.
`timescale 1ns / 1ps
// One fraction is held in lowest terms with a positive denominator. A request word
// carries an operation (load, add, compare) and an operand fraction; each request
// gives exactly one response word. The block handles one word at a time: req_stall
// is high from acceptance until the response is loaded into the output register, and
// the next request can be taken while that response still waits. The unused kind
// skips all arithmetic. A nonzero operand is reduced by a binary gcd (one shift or
// one 64-bit subtract per cycle), followed by two restoring divisions of 64-bit
// dividends. Add and compare then run two or three shift-add products. Add reduces
// the 64-bit sum through the same gcd and divider again. Load with a value that does
// not fit, or an add whose reduced sum does not fit, sets overflow and keeps the
// stored value. An operand with a zero part counts as 0/1.
module rational_accumulator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ra_pkg::req_t  req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ra_pkg::rsp_t  rsp
);
	import ra_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_GCD   = 4'd2;
	localparam logic [3:0] S_DIV1  = 4'd3;
	localparam logic [3:0] S_DIV2  = 4'd4;
	localparam logic [3:0] S_RDONE = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_MDONE = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	localparam logic [1:0] SEL_P1 = 2'd0;
	localparam logic [1:0] SEL_P2 = 2'd1;
	localparam logic [1:0] SEL_P3 = 2'd2;

	localparam logic [63:0] LIMIT = 64'(1) << (VALUE_WIDTH - 1);

	logic [3:0]         state_q;
	logic [1:0]         kind_q;
	logic signed [31:0] on_q, od_q;
	logic               ret_sum_q;
	logic               r_neg_q;
	logic [63:0]        un_q, ud_q, a_q, b_q;
	logic [63:0]        dvd_q, rem_q;
	logic [5:0]         cnt_q;
	logic               op_neg_q;
	logic [31:0]        op_nm_q, op_dm_q;
	logic [1:0]         mul_sel_q;
	logic [63:0]        mcand_q, prod_q, p1_q, p2_q;
	logic [31:0]        mplier_q;
	logic signed [31:0] acc_num_q;
	logic [30:0]        acc_den_q;
	logic               less_q, equal_q, ovf_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// magnitudes
	logic [31:0] on_mag, od_mag, acc_mag;
	assign on_mag  = on_q[31] ? 32'(-on_q) : on_q;
	assign od_mag  = od_q[31] ? 32'(-od_q) : od_q;
	assign acc_mag = acc_num_q[31] ? 32'(-acc_num_q) : acc_num_q;

	// divider trial subtract
	logic [64:0] rem_sh, trial;
	logic        qbit;
	assign rem_sh = {rem_q, dvd_q[63]};
	assign trial  = rem_sh - {1'b0, a_q};
	assign qbit   = (rem_sh >= {1'b0, a_q});

	// multiplier accumulate
	logic [63:0] prod_nx;
	assign prod_nx = prod_q + (mplier_q[0] ? mcand_q : 64'd0);

	// signed cross products and their sum
	logic [63:0]        p2_src;
	logic signed [65:0] s1, s2, sum;
	logic [63:0]        sum_mag;
	assign p2_src  = (mul_sel_q == SEL_P2) ? prod_q : p2_q;
	assign s1      = acc_num_q[31] ? -$signed({2'b00, p1_q}) : $signed({2'b00, p1_q});
	assign s2      = op_neg_q ? -$signed({2'b00, p2_src}) : $signed({2'b00, p2_src});
	assign sum     = s1 + s2;
	assign sum_mag = sum[65] ? 64'(-sum) : sum[63:0];

	// operand equality against the store
	logic signed [32:0] op_sval;
	logic               eq_w;
	assign op_sval = op_neg_q ? -$signed({1'b0, op_nm_q}) : $signed({1'b0, op_nm_q});
	assign eq_w    = ({acc_num_q[31], acc_num_q} == op_sval) && ({1'b0, acc_den_q} == op_dm_q);

	// range check of a reduced fraction
	logic fits_w;
	assign fits_w = (r_neg_q ? (un_q <= LIMIT) : (un_q < LIMIT)) && (ud_q != 64'd0)
		&& (ud_q < LIMIT);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_num_q   <= '0;
			acc_den_q   <= 31'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			// a taken response clears valid unless a new one is loaded now
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q  <= req.kind;
						on_q    <= req.operand_num;
						od_q    <= req.operand_den;
						state_q <= S_START;
					end
				end
				S_START: begin
					less_q    <= 1'b0;
					equal_q   <= 1'b0;
					ovf_q     <= 1'b0;
					ret_sum_q <= 1'b0;
					if (kind_q == KIND_NONE) begin
						state_q <= S_FIN;
					end else if (on_q == 32'sd0 || od_q == 32'sd0) begin
						r_neg_q <= 1'b0;
						un_q    <= 64'd0;
						ud_q    <= 64'd1;
						state_q <= S_RDONE;
					end else begin
						r_neg_q <= on_q[31] ^ od_q[31];
						un_q    <= {32'd0, on_mag};
						ud_q    <= {32'd0, od_mag};
						a_q     <= {32'd0, on_mag};
						b_q     <= {32'd0, od_mag};
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					// binary gcd; common factors of two leave un/ud as they go
					if (a_q == b_q) begin
						dvd_q   <= un_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV1;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q  <= a_q >> 1;
						b_q  <= b_q >> 1;
						un_q <= un_q >> 1;
						ud_q <= ud_q >> 1;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q > b_q) begin
						a_q <= a_q - b_q;
					end else begin
						b_q <= b_q - a_q;
					end
				end
				S_DIV1, S_DIV2: begin
					// restoring division by the odd gcd, one quotient bit per cycle
					rem_q <= qbit ? trial[63:0] : rem_sh[63:0];
					dvd_q <= {dvd_q[62:0], qbit};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						if (state_q == S_DIV1) begin
							un_q    <= {dvd_q[62:0], qbit};
							dvd_q   <= ud_q;
							rem_q   <= '0;
							state_q <= S_DIV2;
						end else begin
							ud_q    <= {dvd_q[62:0], qbit};
							state_q <= S_RDONE;
						end
					end
				end
				S_RDONE: begin
					if (ret_sum_q || kind_q == KIND_LOAD) begin
						if (fits_w) begin
							acc_num_q <= r_neg_q ? 32'(-un_q[31:0]) : un_q[31:0];
							acc_den_q <= ud_q[30:0];
						end else begin
							ovf_q <= 1'b1;
						end
						state_q <= S_FIN;
					end else begin
						op_neg_q  <= r_neg_q;
						op_nm_q   <= un_q[31:0];
						op_dm_q   <= ud_q[31:0];
						mul_sel_q <= SEL_P1;
						mcand_q   <= {32'd0, acc_mag};
						mplier_q  <= ud_q[31:0];
						prod_q    <= '0;
						cnt_q     <= '0;
						state_q   <= S_MUL;
					end
				end
				S_MUL: begin
					// shift-add, one multiplier bit per cycle
					prod_q   <= prod_nx;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= S_MDONE;
					end
				end
				S_MDONE: begin
					prod_q <= '0;
					cnt_q  <= '0;
					case (mul_sel_q)
						SEL_P1: begin
							p1_q      <= prod_q;
							mul_sel_q <= SEL_P2;
							mcand_q   <= {32'd0, op_nm_q};
							mplier_q  <= {1'b0, acc_den_q};
							state_q   <= S_MUL;
						end
						SEL_P2: begin
							p2_q <= prod_q;
							if (kind_q == KIND_COMPARE) begin
								less_q  <= (s1 < s2);
								equal_q <= eq_w;
								state_q <= S_FIN;
							end else begin
								mul_sel_q <= SEL_P3;
								mcand_q   <= {32'd0, 1'b0, acc_den_q};
								mplier_q  <= op_dm_q;
								state_q   <= S_MUL;
							end
						end
						default: begin
							// sum over product of denominators, then reduce
							ret_sum_q <= 1'b1;
							if (sum == 66'sd0) begin
								r_neg_q <= 1'b0;
								un_q    <= 64'd0;
								ud_q    <= 64'd1;
								state_q <= S_RDONE;
							end else begin
								r_neg_q <= sum[65];
								un_q    <= sum_mag;
								ud_q    <= prod_q;
								a_q     <= sum_mag;
								b_q     <= prod_q;
								state_q <= S_GCD;
							end
						end
					endcase
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.result_num <= acc_num_q;
						rsp_q.result_den <= acc_den_q;
						rsp_q.is_nonzero <= (acc_num_q != 32'sd0);
						rsp_q.is_less    <= less_q;
						rsp_q.is_equal   <= equal_q;
						rsp_q.overflow   <= ovf_q;
						rsp_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

>>> rtl/ra_checker.sv
// Port-level checker for the rational accumulator, bound to the top level.
// Depends on ra_pkg and rational_accumulator_defines.svh.
`timescale 1ns / 1ps
`include "rational_accumulator_defines.svh"
module ra_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         req_valid,
	input logic         req_stall,
	input logic         rsp_valid,
	input logic         rsp_stall,
	input ra_pkg::rsp_t rsp
);
	import ra_pkg::*;

	// a held response word stays offered
	`RA_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
	// an accepted word keeps the block busy next cycle
	`RA_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	// stored denominator is never zero
	`RA_ASSERT_IMP(a_den_nonzero, rsp_valid, rsp.result_den != 31'd0)
	// compare flags are exclusive and never come with overflow
	`RA_ASSERT_IMP(a_flags_excl, rsp_valid,
		!(rsp.is_less && rsp.is_equal) && !(rsp.overflow && (rsp.is_less || rsp.is_equal)))
endmodule

bind rational_accumulator ra_checker u_ra_checker (.*);
